@@ design/smf_pkg.sv @@
// Shared types and constants for the MIDI file note extractor.
`default_nettype none
package smf_pkg;

  localparam logic [3:0] PH_HEADER   = 4'd0;
  localparam logic [3:0] PH_IGNORE   = 4'd1;
  localparam logic [3:0] PH_HDRSKIP  = 4'd2;
  localparam logic [3:0] PH_SCAN     = 4'd3;
  localparam logic [3:0] PH_TRKLEN   = 4'd4;
  localparam logic [3:0] PH_DELTA    = 4'd5;
  localparam logic [3:0] PH_STATUS   = 4'd6;
  localparam logic [3:0] PH_METATYPE = 4'd7;
  localparam logic [3:0] PH_LENVLQ   = 4'd8;
  localparam logic [3:0] PH_NOTE1    = 4'd9;
  localparam logic [3:0] PH_NOTE2    = 4'd10;
  localparam logic [3:0] PH_SKIP     = 4'd11;
  localparam logic [3:0] PH_DONE     = 4'd12;

  localparam logic [31:0] MTHD_TAG   = 32'h4D546864;
  localparam logic [31:0] MTRK_TAG   = 32'h4D54726B;
  localparam logic [15:0] PPQ_DEFAULT = 16'd96;
  localparam logic [31:0] MIN_FILE_LEN = 32'd14;
  localparam logic [7:0]  ST_META    = 8'hFF;
  localparam logic [7:0]  ST_SYSEX   = 8'hF0;
  localparam logic [7:0]  ST_SYSEX_E = 8'hF7;
  localparam logic [3:0]  TY_NOTEOFF = 4'h8;
  localparam logic [3:0]  TY_NOTEON  = 4'h9;
  localparam logic [3:0]  TY_POLYAT  = 4'hA;
  localparam logic [3:0]  TY_CTRL    = 4'hB;
  localparam logic [3:0]  TY_BEND    = 4'hE;

  localparam logic KIND_NOTE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // one queued word: a note event, or the summary before the clip division
  typedef struct packed {
    logic        kind;
    logic [7:0]  status;
    logic [7:0]  note;
    logic [7:0]  vel;
    logic [31:0] tick;     // note tick, or largest note tick in a summary
    logic [11:0] count;
    logic [15:0] ppq;
    logic        valid;
    logic        loaded;
  } smf_rec_t;

endpackage
`default_nettype wire

@@ design/smf_note_event_extractor.sv @@
// Top level: MIDI file byte stream in, note events and a summary word out.
// Path: a note word passes through a queue slot and then the output register;
// the summary does the same, or goes through the 33-step divider first when the clip length needs it.
// Throughput: one byte per cycle; the input stalls only while fewer than two
// queue slots are free (output held off). Reset clears all parse state and sets
// file_length to 1.
`default_nettype none
module smf_note_event_extractor
  import smf_pkg::*;
#(
  parameter int MAX_NOTES = 2048
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // event_status, note_number, velocity, abs_tick, notes_stored,
  // ticks_per_quarter, clip_beats, loaded, zero pad
  output logic [119:0]      m_axis_tdata,
  output logic              m_axis_tuser,   // kind
  output logic              m_axis_tlast,   // last
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  logic [31:0] flen_q;
  logic        acc, wr0, wr1, pop, empty, room2;
  smf_rec_t    rec0, rec1, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? flen_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) flen_q <= 32'd1;
    else if (psel && penable && pwrite && paddr[2] == 1'b0) flen_q <= pwdata;
  end

  assign s_axis_tready = room2;
  assign acc = s_axis_tvalid && room2;

  smf_front #(.MAX_NOTES(MAX_NOTES)) u_front (
    .clk_i, .rst_ni, .acc_i(acc), .byte_i(s_axis_tdata), .file_len_i(flen_q),
    .wr0_o(wr0), .rec0_o(rec0), .wr1_o(wr1), .rec1_o(rec1)
  );

  smf_fifo u_fifo (
    .clk_i, .rst_ni, .wr0_i(wr0), .rec0_i(rec0), .wr1_i(wr1), .rec1_i(rec1),
    .pop_i(pop), .head_o(head), .empty_o(empty), .room2_o(room2)
  );

  smf_back u_back (
    .clk_i, .rst_ni, .head_i(head), .empty_i(empty), .pop_o(pop),
    .m_tvalid_o(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_o(m_axis_tdata), .m_tuser_o(m_axis_tuser), .m_tlast_o(m_axis_tlast)
  );
endmodule
`default_nettype wire

@@ design/smf_fifo.sv @@
// Short queue between the parser and the output stage, two writes per cycle.
`default_nettype none
module smf_fifo
  import smf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     wr0_i,
  input  wire smf_rec_t rec0_i,
  input  wire logic     wr1_i,
  input  wire smf_rec_t rec1_i,
  input  wire logic     pop_i,
  output smf_rec_t      head_o,
  output logic          empty_o,
  output logic          room2_o
);
  smf_rec_t    mem_q [4];
  logic [1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0]  cnt_q, cnt_d;

  assign head_o  = mem_q[rptr_q];
  assign empty_o = (cnt_q == 3'd0);
  assign room2_o = (cnt_q <= 3'd2);

  always_comb begin
    wptr_d = wptr_q + {1'b0, wr0_i} + {1'b0, wr1_i};
    rptr_d = rptr_q + {1'b0, pop_i};
    cnt_d  = cnt_q + {2'b0, wr0_i} + {2'b0, wr1_i} - {2'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (wr0_i) mem_q[wptr_q] <= rec0_i;
    if (wr1_i) mem_q[wptr_q + {1'b0, wr0_i}] <= rec1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule
`default_nettype wire

@@ design/smf_front.sv @@
// Byte parser: header, chunk scan, track events; queues notes and the summary.
`default_nettype none
module smf_front
  import smf_pkg::*;
#(
  parameter int MAX_NOTES = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        acc_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [31:0] file_len_i,
  output logic             wr0_o,
  output smf_rec_t         rec0_o,
  output logic             wr1_o,
  output smf_rec_t         rec1_o
);
  localparam int CW = $clog2(MAX_NOTES + 1);

  logic [31:0] pos_q, pos_d, hlen_q, hlen_d, win_q, win_d, trk_q, trk_d;
  logic [31:0] vlq_q, vlq_d, skip_q, skip_d, tick_q, tick_d, maxt_q, maxt_d;
  logic [15:0] ppq_q, ppq_d, ppq_tmp, ppq_eff;
  logic [3:0]  ph_q, ph_d;
  logic [7:0]  rs_q, rs_d, held_q, held_d, st;
  logic [CW-1:0] cnt_q, cnt_d;
  logic        stop_q, stop_d, valid;
  logic [31:0] vlq_new;
  logic [3:0]  ty;
  smf_rec_t    note_rec, sum_rec;
  logic        note_wr, sum_wr;

  always_comb begin
    pos_d = pos_q; hlen_d = hlen_q; win_d = win_q; trk_d = trk_q;
    vlq_d = vlq_q; skip_d = skip_q; tick_d = tick_q; maxt_d = maxt_q;
    ppq_d = ppq_q; ph_d = ph_q; rs_d = rs_q; held_d = held_q;
    cnt_d = cnt_q; stop_d = stop_q;
    note_wr = 1'b0; sum_wr = 1'b0;
    note_rec = '0; sum_rec = '0;
    vlq_new = {vlq_q[24:0], byte_i[6:0]};
    ty = 4'h0; st = 8'h0; ppq_tmp = 16'h0; ppq_eff = 16'h0; valid = 1'b0;
    if (acc_i && ph_q != PH_DONE) begin
      if (ph_q != PH_HEADER && ph_q != PH_IGNORE) begin
        if (pos_q == 32'd12) ppq_d = {byte_i, 8'h00};
        else if (pos_q == 32'd13) begin
          ppq_tmp = {ppq_q[15:8], byte_i};
          ppq_d = (ppq_tmp == 16'h0) ? PPQ_DEFAULT : ppq_tmp;
        end
      end
      if (!stop_q) begin
        unique case (ph_q)
          PH_HEADER: begin
            if (pos_q < 32'd4) begin
              win_d = {win_q[23:0], byte_i};
              if (pos_q == 32'd3 && (win_d != MTHD_TAG || file_len_i < MIN_FILE_LEN))
                ph_d = PH_IGNORE;
            end else begin
              hlen_d = {hlen_q[23:0], byte_i};
              if (pos_q >= 32'd7) begin
                if (hlen_d == 32'h0) begin
                  ph_d = PH_SCAN; win_d = '0;
                end else begin
                  skip_d = hlen_d; ph_d = PH_HDRSKIP;
                end
              end
            end
          end
          PH_IGNORE, PH_DONE: ;
          PH_HDRSKIP: begin
            if (skip_q <= 32'd1) begin
              skip_d = '0; ph_d = PH_SCAN; win_d = '0;
            end else skip_d = skip_q - 32'd1;
          end
          PH_SCAN: begin
            win_d = {win_q[23:0], byte_i};
            if (win_d == MTRK_TAG) begin
              if ({1'b0, pos_q} + 33'd5 <= {1'b0, file_len_i}) begin
                ph_d = PH_TRKLEN; skip_d = 32'd4; trk_d = '0;
              end else stop_d = 1'b1;
            end
          end
          PH_TRKLEN: begin
            trk_d = {trk_q[23:0], byte_i};
            skip_d = skip_q - 32'd1;
            if (skip_d == 32'h0) begin
              if ({1'b0, pos_q} + 33'd1 + {1'b0, trk_d} > {1'b0, file_len_i}) stop_d = 1'b1;
              else if (trk_d == 32'h0) begin
                ph_d = PH_SCAN; win_d = '0;
              end else begin
                ph_d = PH_DELTA; tick_d = '0; vlq_d = '0;
              end
            end
          end
          default: begin
            // track body
            unique case (ph_q)
              PH_DELTA: begin
                vlq_d = vlq_new;
                if (!byte_i[7]) begin
                  tick_d = tick_q + vlq_new; vlq_d = '0; ph_d = PH_STATUS;
                end
              end
              PH_STATUS: begin
                if (byte_i == ST_META) begin
                  if (trk_q >= 32'd3) rs_d = '0;
                  ph_d = PH_METATYPE;
                end else if (byte_i == ST_SYSEX || byte_i == ST_SYSEX_E) begin
                  rs_d = '0; vlq_d = '0; ph_d = PH_LENVLQ;
                end else if (byte_i[7]) begin
                  rs_d = byte_i;
                  ty = byte_i[7:4];
                  if (ty == TY_NOTEOFF || ty == TY_NOTEON) ph_d = PH_NOTE1;
                  else begin
                    skip_d = (ty == TY_POLYAT || ty == TY_CTRL || ty == TY_BEND)
                             ? 32'd2 : 32'd1;
                    ph_d = PH_SKIP;
                  end
                end else begin
                  ty = rs_q[7:4];
                  if (ty == TY_NOTEOFF || ty == TY_NOTEON) begin
                    held_d = byte_i; ph_d = PH_NOTE2;
                  end else if (ty == TY_POLYAT || ty == TY_CTRL || ty == TY_BEND) begin
                    skip_d = 32'd1; ph_d = PH_SKIP;
                  end else ph_d = PH_DELTA;
                end
              end
              PH_METATYPE: begin
                vlq_d = '0; ph_d = PH_LENVLQ;
              end
              PH_LENVLQ: begin
                vlq_d = vlq_new;
                if (!byte_i[7]) begin
                  skip_d = vlq_new; vlq_d = '0;
                  ph_d = (vlq_new != 32'h0) ? PH_SKIP : PH_DELTA;
                end
              end
              PH_NOTE1: begin
                held_d = byte_i; ph_d = PH_NOTE2;
              end
              PH_NOTE2: begin
                if (cnt_q < CW'(MAX_NOTES)) begin
                  st = rs_q;
                  if (rs_q[7:4] == TY_NOTEON && byte_i == 8'h0) st = {TY_NOTEOFF, rs_q[3:0]};
                  note_wr = 1'b1;
                  note_rec.kind = KIND_NOTE;
                  note_rec.status = st;
                  note_rec.note = held_q;
                  note_rec.vel = byte_i;
                  note_rec.tick = tick_q;
                  cnt_d = cnt_q + CW'(1);
                  if (tick_q > maxt_q) maxt_d = tick_q;
                end
                ph_d = PH_DELTA;
              end
              default: begin
                if (skip_q <= 32'd1) begin
                  skip_d = '0; ph_d = PH_DELTA;
                end else skip_d = skip_q - 32'd1;
              end
            endcase
            if (trk_q <= 32'd1) begin
              trk_d = '0; vlq_d = '0; skip_d = '0; ph_d = PH_SCAN; win_d = '0;
            end else trk_d = trk_q - 32'd1;
          end
        endcase
      end
      if ({1'b0, pos_q} + 33'd1 >= {1'b0, file_len_i}) begin
        valid = (ph_d != PH_HEADER && ph_d != PH_IGNORE);
        ppq_eff = (ppq_d != 16'h0) ? ppq_d : PPQ_DEFAULT;
        sum_wr = 1'b1;
        sum_rec.kind = KIND_SUMMARY;
        sum_rec.count = 12'(cnt_d);
        sum_rec.tick = maxt_d;
        sum_rec.valid = valid;
        sum_rec.ppq = valid ? ppq_eff : 16'h0;
        sum_rec.loaded = valid && (cnt_d != '0);
        ph_d = PH_DONE;
      end
      pos_d = pos_q + 32'd1;
    end
  end

  // a lone summary goes through port 0
  assign wr0_o  = note_wr | sum_wr;
  assign rec0_o = note_wr ? note_rec : sum_rec;
  assign wr1_o  = note_wr & sum_wr;
  assign rec1_o = sum_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; hlen_q <= '0; win_q <= '0; trk_q <= '0;
      vlq_q <= '0; skip_q <= '0; tick_q <= '0; maxt_q <= '0;
      ppq_q <= '0; ph_q <= PH_HEADER; rs_q <= '0; held_q <= '0;
      cnt_q <= '0; stop_q <= 1'b0;
    end else begin
      pos_q <= pos_d; hlen_q <= hlen_d; win_q <= win_d; trk_q <= trk_d;
      vlq_q <= vlq_d; skip_q <= skip_d; tick_q <= tick_d; maxt_q <= maxt_d;
      ppq_q <= ppq_d; ph_q <= ph_d; rs_q <= rs_d; held_q <= held_d;
      cnt_q <= cnt_d; stop_q <= stop_d;
    end
  end
endmodule
`default_nettype wire

@@ design/smf_back.sv @@
// Output stage: forwards notes, divides for the clip length of a summary with a nonzero largest tick.
`default_nettype none
module smf_back
  import smf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire smf_rec_t     head_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              m_tvalid_o,
  input  wire logic         m_tready_i,
  output logic [119:0]      m_tdata_o,
  output logic              m_tuser_o,
  output logic              m_tlast_o
);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic        st_q, st_d;
  logic        mv_q, mv_d;
  smf_rec_t    o_q, o_d, sum_q, sum_d;
  logic [32:0] clip_q, clip_d, num_q, num_d, quo_q, quo_d;
  logic [17:0] den_q, den_d;
  logic [18:0] rem_q, rem_d, rem_sh;
  logic [5:0]  it_q, it_d;
  logic        out_free;
  logic [31:0] tick_out;

  assign out_free = !mv_q || m_tready_i;

  always_comb begin
    st_d = st_q; mv_d = mv_q; o_d = o_q; sum_d = sum_q; clip_d = clip_q;
    num_d = num_q; quo_d = quo_q; den_d = den_q; rem_d = rem_q; it_d = it_q;
    pop_o = 1'b0;
    rem_sh = {rem_q[17:0], num_q[32]};
    if (mv_q && m_tready_i) mv_d = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (head_i.kind == KIND_NOTE) begin
            if (out_free) begin
              pop_o = 1'b1; o_d = head_i; clip_d = '0; mv_d = 1'b1;
            end
          end else if (!head_i.valid || head_i.tick == 32'h0) begin
            if (out_free) begin
              pop_o = 1'b1; o_d = head_i; mv_d = 1'b1;
              clip_d = head_i.valid ? 33'd4 : 33'd0;
            end
          end else begin
            pop_o = 1'b1;
            sum_d = head_i;
            den_d = {head_i.ppq, 2'b00};
            num_d = {1'b0, head_i.tick} + {15'h0, head_i.ppq, 2'b00} - 33'd1;
            rem_d = '0; quo_d = '0; it_d = 6'd33;
            st_d = ST_DIV;
          end
        end
      end
      default: begin
        if (it_q != 6'd0) begin
          // restoring division, one quotient bit per cycle
          if (rem_sh >= {1'b0, den_q}) begin
            rem_d = rem_sh - {1'b0, den_q}; quo_d = {quo_q[31:0], 1'b1};
          end else begin
            rem_d = rem_sh; quo_d = {quo_q[31:0], 1'b0};
          end
          num_d = {num_q[31:0], 1'b0};
          it_d = it_q - 6'd1;
        end else if (out_free) begin
          o_d = sum_q; clip_d = {quo_q[30:0], 2'b00}; mv_d = 1'b1; st_d = ST_IDLE;
        end
      end
    endcase
  end

  // the summary carries the largest tick only for the divider; its word shows zero
  assign tick_out   = (o_q.kind == KIND_SUMMARY) ? 32'h0 : o_q.tick;
  assign m_tvalid_o = mv_q;
  assign m_tuser_o  = o_q.kind;
  assign m_tlast_o  = o_q.kind;
  assign m_tdata_o  = {2'b00, o_q.loaded, clip_q, o_q.ppq, o_q.count, tick_out,
                       o_q.vel, o_q.note, o_q.status};

  always_ff @(posedge clk_i) begin
    o_q <= o_d; sum_q <= sum_d; clip_q <= clip_d; num_q <= num_d;
    quo_q <= quo_d; den_q <= den_d; rem_q <= rem_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; mv_q <= 1'b0; it_q <= '0;
    end else begin
      st_q <= st_d; mv_q <= mv_d; it_q <= it_d;
    end
  end
endmodule
`default_nettype wire
